@@ rtl/blockwise_adler32_checksum_defines.svh @@
// Assertion macros for the checker file.
`ifndef BLOCKWISE_ADLER32_CHECKSUM_DEFINES_SVH
`define BLOCKWISE_ADLER32_CHECKSUM_DEFINES_SVH

// Condition in the same cycle implies the consequence in that cycle.
`define BA32_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ba32 check failed: same-cycle implication");

// Condition (a sequence) implies the consequence in the next cycle.
`define BA32_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ba32 check failed: next-cycle implication");

`endif

@@ rtl/ba32_pkg.sv @@
package ba32_pkg;

	// Adler-32 modulus, sized for the 17-bit intermediate sums.
	localparam logic [16:0] ADLER_MOD = 17'd65521;

	// Width of the byte count and of the block length register.
	localparam int unsigned FILL_W = 21;

	// Block length after reset.
	localparam logic [FILL_W-1:0] BLOCK_LENGTH_RESET = 21'd65536;

	// Running sums of the current block.
	typedef struct packed {
		logic [15:0] high;
		logic [15:0] low;
	} sums_t;

	// Sums at the start of every block.
	localparam sums_t SUMS_START = '{high: 16'd0, low: 16'd1};

endpackage

@@ rtl/ba32_step.sv @@
module ba32_step (
	input  ba32_pkg::sums_t sums,
	input  logic [7:0]      data_byte,
	output ba32_pkg::sums_t sums_next
);

	logic [16:0] low_add;
	logic [16:0] low_red;
	logic [16:0] high_add;
	logic [16:0] high_red;

	// Low sum: add the byte, then one conditional subtraction of the modulus.
	always_comb begin
		low_add = {1'b0, sums.low} + {9'd0, data_byte};
		if (low_add >= ba32_pkg::ADLER_MOD) begin
			low_red = low_add - ba32_pkg::ADLER_MOD;
		end else begin
			low_red = low_add;
		end
	end

	// High sum: add the updated low sum, reduced the same way.
	always_comb begin
		high_add = {1'b0, sums.high} + {1'b0, low_red[15:0]};
		if (high_add >= ba32_pkg::ADLER_MOD) begin
			high_red = high_add - ba32_pkg::ADLER_MOD;
		end else begin
			high_red = high_add;
		end
	end

	assign sums_next.low  = low_red[15:0];
	assign sums_next.high = high_red[15:0];

endmodule

@@ rtl/blockwise_adler32_checksum.sv @@
// Channel   Handshake              Payload
// in        in_valid / in_stall    data_byte[7:0], end_of_data
// out       out_valid / out_stall  checksum[31:0], final_block
// cfg       cfg_we                 cfg_wdata[20:0] (block length)
//
// One byte is taken per cycle unless stalled; results pass the input and result registers.
// The rate is set by the low/high sum loop, which closes through ba32_step and sums_q.
// Reset sets the sums to 1 and 0, the byte count to 0 and the block length to 65536.
// A stalled result holds and also holds the byte in the input register,
// so in_stall rises once that register is full.
module blockwise_adler32_checksum (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] checksum,
	output logic        final_block,
	input  logic        cfg_we,
	input  logic [20:0] cfg_wdata
);

	logic                         valid_s1;
	logic [7:0]                   byte_s1;
	logic                         last_s1;
	ba32_pkg::sums_t              sums_q;
	ba32_pkg::sums_t              sums_next;
	logic [ba32_pkg::FILL_W-1:0]  fill_q;
	logic [ba32_pkg::FILL_W-1:0]  fill_inc;
	logic [ba32_pkg::FILL_W-1:0]  block_length_q;
	logic                         out_valid_q;
	logic [31:0]                  checksum_q;
	logic                         final_q;
	logic                         out_free;
	logic                         advance;
	logic                         close_block;

	// The result register can take a new beat when it is empty or being drained.
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= end_of_data;
		end
	end

	// Block length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_length_q <= ba32_pkg::BLOCK_LENGTH_RESET;
		end else if (cfg_we) begin
			block_length_q <= cfg_wdata;
		end
	end

	// Sum update for the byte in the input register.
	ba32_step u_step (
		.sums      (sums_q),
		.data_byte (byte_s1),
		.sums_next (sums_next)
	);

	// The block closes on the end mark or when the count reaches the length.
	assign fill_inc    = fill_q + 1'b1;
	assign close_block = last_s1 || (fill_inc >= block_length_q);

	// Running state: restart after a closed block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q <= ba32_pkg::SUMS_START;
			fill_q <= '0;
		end else if (advance) begin
			if (close_block) begin
				sums_q <= ba32_pkg::SUMS_START;
				fill_q <= '0;
			end else begin
				sums_q <= sums_next;
				fill_q <= fill_inc;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && close_block;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && close_block) begin
			checksum_q <= {sums_next.high, sums_next.low};
			final_q    <= last_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign checksum    = checksum_q;
	assign final_block = final_q;

endmodule

@@ rtl/ba32_checker.sv @@
`include "blockwise_adler32_checksum_defines.svh"

module ba32_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        end_of_data,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] checksum,
	input logic        final_block
);

	// A stalled result beat holds.
	`BA32_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(checksum) && $stable(final_block))

	// Both halves of the checksum stay below the modulus.
	`BA32_ASSERT_SAME(a_sums_reduced, out_valid, (checksum[31:16] < 16'd65521) && (checksum[15:0] < 16'd65521))

	// The input side only stalls while the result side is stalled with a beat.
	`BA32_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall)

	// An end mark gives a final result via register s1 when the output drains.
	`BA32_ASSERT_NEXT(a_end_latency, (in_valid && !in_stall && end_of_data) ##1 (!out_valid || !out_stall), out_valid && final_block)

endmodule

bind blockwise_adler32_checksum ba32_checker u_ba32_checker (.*);

@@ bench/tb.sv @@
module tb;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RANDOM_BYTES = 850;
	localparam int unsigned SETTLE_CYCLES = 8;

	typedef struct {
		logic [31:0] sum;
		logic        fin;
	} checksum_beat_t;

	// Tracks the running Adler sums and holds the checksums still owed by the block.
	class block_checksum_tracker;
		logic [ba32_pkg::FILL_W-1:0] block_len;
		logic [ba32_pkg::FILL_W-1:0] fill;
		ba32_pkg::sums_t             sums;
		checksum_beat_t              due_checksums[$];
		int unsigned                 bytes_taken;
		int unsigned                 checksums_seen;
		int unsigned                 mismatches;

		function new();
			block_len = ba32_pkg::BLOCK_LENGTH_RESET;
			fill = '0;
			sums = ba32_pkg::SUMS_START;
			bytes_taken = 0;
			checksums_seen = 0;
			mismatches = 0;
		endfunction

		function void set_block_len(logic [ba32_pkg::FILL_W-1:0] len);
			block_len = len;
		endfunction

		// Fold one accepted byte into the sums and queue a checksum if the block closes.
		function void take_byte(logic [7:0] b, logic last);
			logic [16:0]    lo;
			logic [16:0]    hi;
			checksum_beat_t due;
			lo = {1'b0, sums.low} + {9'd0, b};
			if (lo >= ba32_pkg::ADLER_MOD) begin
				lo = lo - ba32_pkg::ADLER_MOD;
			end
			hi = {1'b0, sums.high} + lo;
			if (hi >= ba32_pkg::ADLER_MOD) begin
				hi = hi - ba32_pkg::ADLER_MOD;
			end
			sums.low = lo[15:0];
			sums.high = hi[15:0];
			fill = fill + 1'b1;
			bytes_taken++;
			if (last || fill >= block_len) begin
				due.sum = sums;
				due.fin = last;
				due_checksums.insert(due_checksums.size(), due);
				sums = ba32_pkg::SUMS_START;
				fill = '0;
			end
		endfunction

		// Compare one accepted output beat against the oldest queued checksum.
		function void match_checksum(logic [31:0] sum, logic fin);
			checksum_beat_t due;
			checksums_seen++;
			if (due_checksums.size() == 0) begin
				$display("%0t: unexpected checksum beat %08h final %0b", $time, sum, fin);
				mismatches++;
				return;
			end
			due = due_checksums.pop_front();
			if (sum !== due.sum) begin
				$display("%0t: checksum expected %08h actual %08h", $time, due.sum, sum);
				mismatches++;
			end
			if (fin !== due.fin) begin
				$display("%0t: final_block expected %0b actual %0b", $time, due.fin, fin);
				mismatches++;
			end
		endfunction

		function int unsigned owed();
			return due_checksums.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        end_of_data;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] checksum;
	logic        final_block;
	logic        cfg_we;
	logic [20:0] cfg_wdata;

	block_checksum_tracker tracker;
	int unsigned           send_idle_pct;
	int unsigned           recv_idle_pct;
	int unsigned           cycle_count;
	int unsigned           random_sent;
	int unsigned           length_writes;

	blockwise_adler32_checksum u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.end_of_data (end_of_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.checksum    (checksum),
		.final_block (final_block),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver stalls at random on the falling edge.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Check every result beat accepted at the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			tracker.match_checksum(checksum, final_block);
		end
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d checksums owed", $time, tracker.owed());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Offer one byte, with a random gap first, and hold it until the beat is taken.
	task automatic push_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		data_byte = b;
		end_of_data = last;
		do begin
			@(posedge clk);
		end while (in_stall);
		tracker.take_byte(b, last);
	endtask

	// Drop valid, then wait until every owed checksum has come out and the pipe is empty.
	task automatic wait_checksums_out();
		@(negedge clk);
		in_valid = 1'b0;
		while (tracker.owed() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_block_length(input logic [20:0] len);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = len;
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_wdata = 21'($urandom());
		tracker.set_block_len(len);
		length_writes++;
	endtask

	// A random run of bytes; ff_heavy pushes the low sum through its modulo.
	task automatic stream_segment(input int unsigned count, input bit ff_heavy,
			input bit end_at_tail);
		logic [7:0] b;
		logic       last;
		for (int unsigned i = 0; i < count; i++) begin
			if (ff_heavy && $urandom_range(9) != 0) begin
				b = 8'hFF;
			end else begin
				case ($urandom_range(9))
					0: b = 8'hFF;
					1: b = 8'h00;
					default: b = 8'($urandom_range(255));
				endcase
			end
			last = (i == count - 1) ? end_at_tail : ($urandom_range(31) == 0);
			push_byte(b, last);
			random_sent++;
		end
	endtask

	// Pick the idle mix from how far the random part has come.
	task automatic pick_idle_mix();
		if (random_sent < RANDOM_BYTES / 3) begin
			send_idle_pct = 23;
			recv_idle_pct = 70;
		end else if (random_sent < 2 * RANDOM_BYTES / 3) begin
			send_idle_pct = 70;
			recv_idle_pct = 23;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	endtask

	initial begin
		logic [20:0] len;
		tracker = new();
		random_sent = 0;
		length_writes = 0;
		send_idle_pct = 23;
		recv_idle_pct = 70;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		end_of_data = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset length: a short partial block closed by the end mark.
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h80, 1'b1);
		wait_checksums_out();

		// Zero length behaves like one: every byte closes its own block.
		write_block_length(21'd0);
		push_byte(8'h01, 1'b0);
		push_byte(8'h7F, 1'b1);
		wait_checksums_out();

		// Full block that also carries the end mark gives one final checksum.
		write_block_length(21'd2);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h55, 1'b0);
		push_byte(8'hAA, 1'b1);
		wait_checksums_out();

		// Shorten the length mid-block: the next byte closes the block at once.
		write_block_length(21'd8);
		for (int i = 0; i < 5; i++) begin
			push_byte(8'($urandom_range(255)), 1'b0);
		end
		wait_checksums_out();
		write_block_length(21'd3);
		push_byte(8'h10, 1'b0);
		push_byte(8'h20, 1'b0);
		push_byte(8'h40, 1'b1);
		wait_checksums_out();

		// Mostly 0xFF bytes under a large block length; random end marks split the run.
		write_block_length(21'd1048576);
		stream_segment(330, 1'b1, 1'b1);
		wait_checksums_out();

		// Random segments over a spread of lengths, extremes included.
		while (random_sent < RANDOM_BYTES) begin
			pick_idle_mix();
			case ($urandom_range(9))
				0: len = 21'd0;
				1: len = 21'd1;
				2, 3, 4: len = 21'($urandom_range(16, 2));
				5: len = 21'($urandom_range(400, 17));
				6: len = 21'd65536;
				7: len = 21'd1048576;
				8: len = 21'h1FFFFF;
				default: len = tracker.block_len;
			endcase
			if (len != tracker.block_len || $urandom_range(3) == 0) begin
				write_block_length(len);
			end
			stream_segment($urandom_range(60, 15), ($urandom_range(7) == 0),
				1'($urandom_range(1)));
			wait_checksums_out();
		end

		$display("Sent %0d bytes over %0d block length writes; %0d checksums checked.",
			tracker.bytes_taken, length_writes, tracker.checksums_seen);
		$display("Idle mixes: sender-light/receiver-heavy, the reverse, then none.");
		if (tracker.mismatches == 0 && tracker.owed() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
